[hw/rtl/graph_bfs_tree_cost_core_macros.svh]
// Assertion helpers for the BFS core. Expect clk_i and rst_ni in scope.
`ifndef GRAPH_BFS_TREE_COST_CORE_MACROS_SVH
`define GRAPH_BFS_TREE_COST_CORE_MACROS_SVH

// same-cycle implication
`define GBTC_ASSERT_IMP(name, ante, cons, msg) \
  name: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define GBTC_ASSERT_NXT(name, ante, cons, msg) \
  name: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

[hw/rtl/gbtc_pkg.sv]
package gbtc_pkg;

  localparam int unsigned MAX_VERTICES_DEF = 32;
  localparam int unsigned MAX_EDGES_DEF    = 64;
  localparam int unsigned WEIGHT_BITS_DEF  = 16;

  localparam int unsigned OP_W        = 2;
  localparam int unsigned VTX_W       = 5;
  localparam int unsigned IN_WEIGHT_W = 16;
  localparam int unsigned VCOUNT_W    = 6;
  localparam int unsigned CNT_W       = VCOUNT_W + 1;
  localparam int unsigned COST_W      = 21;
  localparam int unsigned QUEUE_DEPTH = 32;
  localparam int unsigned QUEUE_AW    = $clog2(QUEUE_DEPTH);
  localparam int unsigned PTR_W       = QUEUE_AW + 1;
  localparam int unsigned STEP_W      = 4;

  localparam logic [VCOUNT_W-1:0] VCOUNT_RESET = VCOUNT_W'(32);
  localparam logic [COST_W-1:0]   COST_MAX     = '1;

  typedef enum logic [OP_W-1:0] {
    OP_ADD    = 2'd0,
    OP_SEARCH = 2'd1,
    OP_CLEAR  = 2'd2,
    OP_NOP    = 2'd3
  } op_e;

  typedef enum logic [3:0] {
    DP_NOP,
    DP_LATCH,
    DP_EDIT,
    DP_INIT,
    DP_POP,
    DP_EVAL,
    DP_DISCOVER,
    DP_EMIT_LAST,
    DP_EMIT_ERR
  } dp_op_e;

  typedef enum logic [3:0] {
    C_NEXT,
    C_ALWAYS,
    C_IS_SEARCH,
    C_SRC_BAD,
    C_Q_EMPTY,
    C_NO_EDGES,
    C_SCAN_ON,
    C_NOT_HIT,
    C_MORE
  } cond_e;

  typedef enum logic [1:0] {
    HOLD_NONE,
    HOLD_IN,
    HOLD_OUT
  } hold_e;

  localparam logic [STEP_W-1:0] ST_FETCH    = 4'd0;
  localparam logic [STEP_W-1:0] ST_DISPATCH = 4'd1;
  localparam logic [STEP_W-1:0] ST_EDIT     = 4'd2;
  localparam logic [STEP_W-1:0] ST_INIT     = 4'd3;
  localparam logic [STEP_W-1:0] ST_SETTLE   = 4'd4;
  localparam logic [STEP_W-1:0] ST_DEQ      = 4'd5;
  localparam logic [STEP_W-1:0] ST_SCAN     = 4'd6;
  localparam logic [STEP_W-1:0] ST_EVAL     = 4'd7;
  localparam logic [STEP_W-1:0] ST_TEST     = 4'd8;
  localparam logic [STEP_W-1:0] ST_DISC     = 4'd9;
  localparam logic [STEP_W-1:0] ST_BACK     = 4'd10;
  localparam logic [STEP_W-1:0] ST_FINAL    = 4'd11;
  localparam logic [STEP_W-1:0] ST_ERR      = 4'd12;

  typedef struct packed {
    hold_e               hold;
    cond_e               cond;
    logic [STEP_W-1:0]   target;
    dp_op_e              op;
  } uword_t;

  typedef struct packed {
    dp_op_e op;
    logic   fire;
  } ctrl_t;

  typedef struct packed {
    logic is_search;
    logic src_bad;
    logic q_empty;
    logic no_edges;
    logic scan_on;
    logic hit;
    logic more;
    logic out_free;
  } stat_t;

  function automatic uword_t mk_uword(hold_e h, cond_e c, logic [STEP_W-1:0] t, dp_op_e o);
    uword_t w;
    w.hold   = h;
    w.cond   = c;
    w.target = t;
    w.op     = o;
    return w;
  endfunction

  // control store
  function automatic uword_t ucode(logic [STEP_W-1:0] step);
    uword_t w;
    case (step)
      ST_FETCH:    w = mk_uword(HOLD_IN,   C_NEXT,      ST_FETCH, DP_LATCH);
      ST_DISPATCH: w = mk_uword(HOLD_NONE, C_IS_SEARCH, ST_INIT,  DP_NOP);
      ST_EDIT:     w = mk_uword(HOLD_NONE, C_ALWAYS,    ST_FETCH, DP_EDIT);
      ST_INIT:     w = mk_uword(HOLD_NONE, C_SRC_BAD,   ST_ERR,   DP_INIT);
      ST_SETTLE:   w = mk_uword(HOLD_NONE, C_NEXT,      ST_FETCH, DP_NOP);
      ST_DEQ:      w = mk_uword(HOLD_NONE, C_Q_EMPTY,   ST_FINAL, DP_POP);
      ST_SCAN:     w = mk_uword(HOLD_NONE, C_NO_EDGES,  ST_DEQ,   DP_NOP);
      ST_EVAL:     w = mk_uword(HOLD_NONE, C_SCAN_ON,   ST_EVAL,  DP_EVAL);
      ST_TEST:     w = mk_uword(HOLD_NONE, C_NOT_HIT,   ST_DEQ,   DP_NOP);
      ST_DISC:     w = mk_uword(HOLD_OUT,  C_MORE,      ST_EVAL,  DP_DISCOVER);
      ST_BACK:     w = mk_uword(HOLD_NONE, C_ALWAYS,    ST_DEQ,   DP_NOP);
      ST_FINAL:    w = mk_uword(HOLD_OUT,  C_ALWAYS,    ST_FETCH, DP_EMIT_LAST);
      ST_ERR:      w = mk_uword(HOLD_OUT,  C_ALWAYS,    ST_FETCH, DP_EMIT_ERR);
      default:     w = mk_uword(HOLD_NONE, C_ALWAYS,    ST_FETCH, DP_NOP);
    endcase
    return w;
  endfunction

endpackage

[hw/rtl/gbtc_if.sv]
interface gbtc_in_if;
  logic                                valid;
  logic                                ready;
  logic [gbtc_pkg::OP_W-1:0]           op;
  logic [gbtc_pkg::VTX_W-1:0]          endpoint_a;
  logic [gbtc_pkg::VTX_W-1:0]          endpoint_b;
  logic [gbtc_pkg::IN_WEIGHT_W-1:0]    weight;
  logic [gbtc_pkg::VTX_W-1:0]          source_vertex;

  modport source (output valid, op, endpoint_a, endpoint_b, weight, source_vertex,
                  input ready);
  modport sink (input valid, op, endpoint_a, endpoint_b, weight, source_vertex,
                output ready);
endinterface

interface gbtc_out_if;
  logic                          valid;
  logic                          ready;
  logic [gbtc_pkg::VTX_W-1:0]    vertex;
  logic [gbtc_pkg::COST_W-1:0]   total_cost;
  logic                          last;
  logic                          source_error;
  logic                          edges_dropped;

  modport source (output valid, vertex, total_cost, last, source_error, edges_dropped,
                  input ready);
  modport sink (input valid, vertex, total_cost, last, source_error, edges_dropped,
                output ready);
endinterface

interface gbtc_cfg_if;
  logic                            valid;
  logic                            ready;
  logic [gbtc_pkg::VCOUNT_W-1:0]   vertex_count;

  modport source (output valid, vertex_count, input ready);
  modport sink (input valid, vertex_count, output ready);
endinterface

[hw/rtl/gbtc_ram.sv]
module gbtc_ram #(
  parameter int unsigned Width = gbtc_pkg::VTX_W,
  parameter int unsigned Depth = gbtc_pkg::QUEUE_DEPTH,
  localparam int unsigned AddrW = (Depth > 1) ? $clog2(Depth) : 1
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AddrW-1:0] waddr_i,
  input  logic [Width-1:0] wdata_i,
  input  logic [AddrW-1:0] raddr_i,
  output logic [Width-1:0] rdata_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

[hw/rtl/gbtc_seq.sv]
module gbtc_seq (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            in_valid_i,
  input  gbtc_pkg::stat_t stat_i,
  output gbtc_pkg::ctrl_t ctrl_o,
  output logic            in_ready_o
);

  logic [gbtc_pkg::STEP_W-1:0] pc_q, pc_d;
  gbtc_pkg::uword_t            uw;
  logic                        go;
  logic                        take;

  assign uw = gbtc_pkg::ucode(pc_q);

  always_comb begin
    case (uw.hold)
      gbtc_pkg::HOLD_NONE: go = 1'b1;
      gbtc_pkg::HOLD_IN:   go = in_valid_i;
      gbtc_pkg::HOLD_OUT:  go = stat_i.out_free;
      default:             go = 1'b0;
    endcase

    case (uw.cond)
      gbtc_pkg::C_NEXT:      take = 1'b0;
      gbtc_pkg::C_ALWAYS:    take = 1'b1;
      gbtc_pkg::C_IS_SEARCH: take = stat_i.is_search;
      gbtc_pkg::C_SRC_BAD:   take = stat_i.src_bad;
      gbtc_pkg::C_Q_EMPTY:   take = stat_i.q_empty;
      gbtc_pkg::C_NO_EDGES:  take = stat_i.no_edges;
      gbtc_pkg::C_SCAN_ON:   take = stat_i.scan_on;
      gbtc_pkg::C_NOT_HIT:   take = !stat_i.hit;
      gbtc_pkg::C_MORE:      take = stat_i.more;
      default:               take = 1'b0;
    endcase

    if (!go) begin
      pc_d = pc_q;
    end else if (take) begin
      pc_d = uw.target;
    end else begin
      pc_d = pc_q + gbtc_pkg::STEP_W'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pc_q <= gbtc_pkg::ST_FETCH;
    end else begin
      pc_q <= pc_d;
    end
  end

  assign ctrl_o.op   = uw.op;
  assign ctrl_o.fire = go;
  assign in_ready_o  = (uw.hold == gbtc_pkg::HOLD_IN);

endmodule

[hw/rtl/gbtc_datapath.sv]
module gbtc_datapath #(
  parameter int unsigned MaxVertices = gbtc_pkg::MAX_VERTICES_DEF,
  parameter int unsigned MaxEdges    = gbtc_pkg::MAX_EDGES_DEF,
  parameter int unsigned WeightBits  = gbtc_pkg::WEIGHT_BITS_DEF
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  gbtc_pkg::ctrl_t                     ctrl_i,
  output gbtc_pkg::stat_t                     stat_o,
  input  logic                                cfg_we_i,
  input  logic [gbtc_pkg::VCOUNT_W-1:0]       cfg_vcount_i,
  input  logic [gbtc_pkg::OP_W-1:0]           op_i,
  input  logic [gbtc_pkg::VTX_W-1:0]          endpoint_a_i,
  input  logic [gbtc_pkg::VTX_W-1:0]          endpoint_b_i,
  input  logic [gbtc_pkg::IN_WEIGHT_W-1:0]    weight_i,
  input  logic [gbtc_pkg::VTX_W-1:0]          source_vertex_i,
  input  logic                                out_ready_i,
  output logic                                out_valid_o,
  output logic [gbtc_pkg::VTX_W-1:0]          vertex_o,
  output logic [gbtc_pkg::COST_W-1:0]         total_cost_o,
  output logic                                last_o,
  output logic                                source_error_o,
  output logic                                edges_dropped_o
);

  localparam int unsigned VW     = gbtc_pkg::VTX_W;
  localparam int unsigned CntW   = gbtc_pkg::CNT_W;
  localparam int unsigned CostW  = gbtc_pkg::COST_W;
  localparam int unsigned PtrW   = gbtc_pkg::PTR_W;
  localparam int unsigned QAW    = gbtc_pkg::QUEUE_AW;
  localparam int unsigned VIdxW  = (MaxVertices > 1) ? $clog2(MaxVertices) : 1;
  localparam int unsigned EcW    = $clog2(MaxEdges + 1);
  localparam int unsigned EAW    = (MaxEdges > 1) ? $clog2(MaxEdges) : 1;
  localparam int unsigned EdgeW  = 2 * VW + WeightBits;
  localparam int unsigned SumW   = ((WeightBits > CostW) ? WeightBits : CostW) + 1;

  logic [gbtc_pkg::VCOUNT_W-1:0] vc_q;
  logic [EcW-1:0]                total_q;
  logic                          flag_q;
  logic                          out_valid_q;

  logic [gbtc_pkg::OP_W-1:0]     op_q;
  logic [VW-1:0]                 a_q, b_q, src_q;
  logic [WeightBits-1:0]         win_q;
  logic [MaxVertices-1:0]        visited_q;
  logic [CostW-1:0]              cost_q;
  logic [PtrW-1:0]               head_q, head_d, tail_q;
  logic [VW-1:0]                 u_q, nb_q, pend_q;
  logic [EcW-1:0]                ei_q, ei_d;
  logic                          hit_q;
  logic [WeightBits-1:0]         wsel_q;

  logic [VW-1:0]                 out_vertex_q;
  logic [CostW-1:0]              out_cost_q;
  logic                          out_last_q, out_err_q, out_drop_q;

  logic                          fire;
  logic [CntW-1:0]               cnt;
  logic                          add_ok, store_full;

  logic                          e_we;
  logic [EdgeW-1:0]              e_rdata;
  logic [VW-1:0]                 ea, eb;
  logic [WeightBits-1:0]         ew;
  logic                          e_ok, touch_a, touches, hit_now;
  logic [VW-1:0]                 nb_now;

  logic                          q_we;
  logic [QAW-1:0]                q_waddr;
  logic [VW-1:0]                 q_wdata, q_rdata;
  logic                          q_room;

  logic [SumW-1:0]               cost_sum;
  logic [CostW-1:0]              cost_sat;
  logic                          emit;

  assign fire = ctrl_i.fire;

  assign cnt = (CntW'(vc_q) > CntW'(MaxVertices)) ? CntW'(MaxVertices) : CntW'(vc_q);

  assign add_ok     = (CntW'(a_q) < cnt) && (CntW'(b_q) < cnt);
  assign store_full = (total_q >= EcW'(MaxEdges));
  assign e_we = fire && (ctrl_i.op == gbtc_pkg::DP_EDIT) && (op_q == gbtc_pkg::OP_ADD)
                && add_ok && !store_full;

  // edge store address follows the next index so data lines up with ei_q
  always_comb begin
    ei_d = ei_q;
    if (fire && ctrl_i.op == gbtc_pkg::DP_POP) begin
      ei_d = '0;
    end else if (fire && ctrl_i.op == gbtc_pkg::DP_EVAL) begin
      ei_d = ei_q + EcW'(1);
    end
  end

  gbtc_ram #(
    .Width (EdgeW),
    .Depth (MaxEdges)
  ) u_edge_ram (
    .clk_i   (clk_i),
    .we_i    (e_we),
    .waddr_i (total_q[EAW-1:0]),
    .wdata_i ({a_q, b_q, win_q}),
    .raddr_i (ei_d[EAW-1:0]),
    .rdata_o (e_rdata)
  );

  assign ea = e_rdata[EdgeW-1 -: VW];
  assign eb = e_rdata[WeightBits +: VW];
  assign ew = e_rdata[WeightBits-1:0];

  assign e_ok    = (CntW'(ea) < cnt) && (CntW'(eb) < cnt);
  assign touch_a = (ea == u_q);
  assign touches = touch_a || (eb == u_q);
  assign nb_now  = touch_a ? eb : ea;
  assign hit_now = e_ok && touches && !visited_q[VIdxW'(nb_now)];

  always_comb begin
    head_d = head_q;
    if (fire && ctrl_i.op == gbtc_pkg::DP_INIT) begin
      head_d = '0;
    end else if (fire && ctrl_i.op == gbtc_pkg::DP_POP) begin
      head_d = head_q + PtrW'(1);
    end
  end

  assign q_room  = (tail_q < PtrW'(gbtc_pkg::QUEUE_DEPTH));
  assign q_we    = fire && ((ctrl_i.op == gbtc_pkg::DP_INIT)
                   || (ctrl_i.op == gbtc_pkg::DP_DISCOVER && q_room));
  assign q_waddr = (ctrl_i.op == gbtc_pkg::DP_INIT) ? '0 : tail_q[QAW-1:0];
  assign q_wdata = (ctrl_i.op == gbtc_pkg::DP_INIT) ? src_q : nb_q;

  gbtc_ram #(
    .Width (VW),
    .Depth (gbtc_pkg::QUEUE_DEPTH)
  ) u_queue_ram (
    .clk_i   (clk_i),
    .we_i    (q_we),
    .waddr_i (q_waddr),
    .wdata_i (q_wdata),
    .raddr_i (head_d[QAW-1:0]),
    .rdata_o (q_rdata)
  );

  assign cost_sum = SumW'(cost_q) + SumW'(wsel_q);
  assign cost_sat = (cost_sum > SumW'(gbtc_pkg::COST_MAX)) ? gbtc_pkg::COST_MAX
                                                          : cost_sum[CostW-1:0];

  assign emit = fire && ((ctrl_i.op == gbtc_pkg::DP_DISCOVER)
                || (ctrl_i.op == gbtc_pkg::DP_EMIT_LAST)
                || (ctrl_i.op == gbtc_pkg::DP_EMIT_ERR));

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vc_q        <= gbtc_pkg::VCOUNT_RESET;
      total_q     <= '0;
      flag_q      <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (cfg_we_i) begin
        vc_q <= cfg_vcount_i;
      end
      if (fire && ctrl_i.op == gbtc_pkg::DP_EDIT) begin
        if (op_q == gbtc_pkg::OP_ADD && add_ok) begin
          if (store_full) begin
            flag_q <= 1'b1;
          end else begin
            total_q <= total_q + EcW'(1);
          end
        end else if (op_q == gbtc_pkg::OP_CLEAR) begin
          total_q <= '0;
          flag_q  <= 1'b0;
        end
      end
      if (emit) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    ei_q   <= ei_d;
    head_q <= head_d;
    if (fire) begin
      case (ctrl_i.op)
        gbtc_pkg::DP_LATCH: begin
          op_q  <= op_i;
          a_q   <= endpoint_a_i;
          b_q   <= endpoint_b_i;
          win_q <= WeightBits'(weight_i);
          src_q <= source_vertex_i;
        end
        gbtc_pkg::DP_INIT: begin
          visited_q <= MaxVertices'(1) << src_q;
          cost_q    <= '0;
          tail_q    <= PtrW'(1);
          pend_q    <= src_q;
        end
        gbtc_pkg::DP_POP: begin
          u_q <= q_rdata;
        end
        gbtc_pkg::DP_EVAL: begin
          hit_q  <= hit_now;
          nb_q   <= nb_now;
          wsel_q <= ew;
        end
        gbtc_pkg::DP_DISCOVER: begin
          visited_q[VIdxW'(nb_q)] <= 1'b1;
          cost_q                  <= cost_sat;
          pend_q                  <= nb_q;
          if (q_room) begin
            tail_q <= tail_q + PtrW'(1);
          end
          out_vertex_q <= pend_q;
          out_cost_q   <= '0;
          out_last_q   <= 1'b0;
          out_err_q    <= 1'b0;
          out_drop_q   <= flag_q;
        end
        gbtc_pkg::DP_EMIT_LAST: begin
          out_vertex_q <= pend_q;
          out_cost_q   <= cost_q;
          out_last_q   <= 1'b1;
          out_err_q    <= 1'b0;
          out_drop_q   <= flag_q;
        end
        gbtc_pkg::DP_EMIT_ERR: begin
          out_vertex_q <= '0;
          out_cost_q   <= '0;
          out_last_q   <= 1'b1;
          out_err_q    <= 1'b1;
          out_drop_q   <= flag_q;
        end
        default: begin
        end
      endcase
    end
  end

  assign stat_o.is_search = (op_q == gbtc_pkg::OP_SEARCH);
  assign stat_o.src_bad   = (CntW'(src_q) >= cnt);
  assign stat_o.q_empty   = (head_q == tail_q);
  assign stat_o.no_edges  = (total_q == '0);
  assign stat_o.scan_on   = !hit_now && ((ei_q + EcW'(1)) < total_q);
  assign stat_o.hit       = hit_q;
  assign stat_o.more      = (ei_q < total_q);
  assign stat_o.out_free  = !out_valid_q || out_ready_i;

  assign out_valid_o     = out_valid_q;
  assign vertex_o        = out_vertex_q;
  assign total_cost_o    = out_cost_q;
  assign last_o          = out_last_q;
  assign source_error_o  = out_err_q;
  assign edges_dropped_o = out_drop_q;

endmodule

[hw/rtl/graph_bfs_tree_cost_core.sv]
// Breadth-first search engine over a stored list of weighted undirected edges.
// Op add stores an edge (dropped edges set a sticky flag, edges touching a
// vertex at or above vertex_count are ignored), op clear empties the store.
// Op search emits each visited vertex in visit order; the last item carries
// the saturated sum of discovering edge weights. A bad source gives a single
// error item. A small microcoded sequencer walks the edge store once per
// dequeued vertex, one edge per cycle through its single read port, pausing
// at each discovery, which waits until the output register is free. One item
// is handled at a time; the output register lets the next item be taken
// while the last result is still waiting.
`include "graph_bfs_tree_cost_core_macros.svh"

module graph_bfs_tree_cost_core #(
  parameter int unsigned MaxVertices = gbtc_pkg::MAX_VERTICES_DEF,
  parameter int unsigned MaxEdges    = gbtc_pkg::MAX_EDGES_DEF,
  parameter int unsigned WeightBits  = gbtc_pkg::WEIGHT_BITS_DEF
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  gbtc_in_if.sink    item_in_i,
  gbtc_out_if.source item_out_o,
  gbtc_cfg_if.sink   cfg_i
);

  gbtc_pkg::ctrl_t ctrl;
  gbtc_pkg::stat_t stat;
  logic            in_ready;

  assign item_in_i.ready = in_ready;
  assign cfg_i.ready     = 1'b1;

  gbtc_seq u_seq (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (item_in_i.valid),
    .stat_i     (stat),
    .ctrl_o     (ctrl),
    .in_ready_o (in_ready)
  );

  gbtc_datapath #(
    .MaxVertices (MaxVertices),
    .MaxEdges    (MaxEdges),
    .WeightBits  (WeightBits)
  ) u_datapath (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .ctrl_i          (ctrl),
    .stat_o          (stat),
    .cfg_we_i        (cfg_i.valid),
    .cfg_vcount_i    (cfg_i.vertex_count),
    .op_i            (item_in_i.op),
    .endpoint_a_i    (item_in_i.endpoint_a),
    .endpoint_b_i    (item_in_i.endpoint_b),
    .weight_i        (item_in_i.weight),
    .source_vertex_i (item_in_i.source_vertex),
    .out_ready_i     (item_out_o.ready),
    .out_valid_o     (item_out_o.valid),
    .vertex_o        (item_out_o.vertex),
    .total_cost_o    (item_out_o.total_cost),
    .last_o          (item_out_o.last),
    .source_error_o  (item_out_o.source_error),
    .edges_dropped_o (item_out_o.edges_dropped)
  );

  `GBTC_ASSERT_IMP(a_err_item_shape, item_out_o.valid && item_out_o.source_error, item_out_o.last && item_out_o.vertex == '0 && item_out_o.total_cost == '0, "error item malformed")
  `GBTC_ASSERT_IMP(a_cost_only_last, item_out_o.valid && !item_out_o.last, item_out_o.total_cost == '0, "cost on non-final item")
  `GBTC_ASSERT_NXT(a_final_emitted, ctrl.fire && ctrl.op == gbtc_pkg::DP_EMIT_LAST, item_out_o.valid && item_out_o.last && !item_out_o.source_error, "final item missing")

endmodule
